@@ sv/q4dq_pkg.sv @@
// ----------------------------------------------------------------------------
// q4dq_pkg: shared types and helpers for the 4-bit nibble dequantizer
// Payload structs, float constants and the per-nibble stage records.
// ----------------------------------------------------------------------------
package q4dq_pkg;

  localparam int unsigned SIG_W  = 24;  // bfloat16 significand with hidden bit, zero-padded to float32 width
  localparam int unsigned MAG_W  = 4;   // |nibble - 8| up to 8
  localparam int unsigned PROD_W = 28;
  localparam int unsigned MSB_W  = 5;

  localparam logic [31:0] QNAN_CANON = 32'h7FC0_0000;
  localparam logic [30:0] INF_BITS   = 31'h7F80_0000;
  localparam logic [3:0]  NIB_MID    = 4'd8;

  typedef struct packed {
    logic [15:0] scale_word;
    logic [7:0]  weight_pair;
  } in_item_t;

  typedef struct packed {
    logic [31:0] low_weight;
    logic [31:0] high_weight;
  } out_item_t;

  // Decoded scale, shared by both lanes.
  typedef struct packed {
    logic       sign;
    logic [7:0] bexp;   // effective exponent (1 for subnormals)
    logic [6:0] man;
    logic       hidden;
    logic       is_nan;
    logic       is_inf;
    logic       is_zero;
  } scale_dec_t;

  // One lane after the multiply.
  typedef struct packed {
    logic              sign;
    logic [PROD_W-1:0] prod;
    logic [7:0]        bexp;
    logic              special;  // result fully decided already
    logic [31:0]       special_val;
  } lane_prod_t;

  // One lane after the leading-one search.
  typedef struct packed {
    logic              sign;
    logic [PROD_W-1:0] prod;
    logic [7:0]        bexp;
    logic [MSB_W-1:0]  msb;
    logic              special;
    logic [31:0]       special_val;
  } lane_norm_t;

  function automatic logic [MSB_W-1:0] find_msb(input logic [PROD_W-1:0] v);
    logic [MSB_W-1:0] r;
    r = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (v[i]) r = MSB_W'(i);
    end
    return r;
  endfunction

endpackage

@@ sv/q4dq_lane.sv @@
// ----------------------------------------------------------------------------
// q4dq_lane: one nibble lane, three register stages
// Multiply, leading-one search, then normalize and pack to float32.
// ----------------------------------------------------------------------------
module q4dq_lane (
  input  logic                 clk,
  input  logic [1:0]           adv,      // adv[0]: stage 1->2, adv[1]: stage 2->3
  input  logic                 adv_in,   // load stage 1
  input  q4dq_pkg::scale_dec_t sdec,
  input  logic [3:0]           nibble,
  output logic [31:0]          result
);
  import q4dq_pkg::*;

  lane_prod_t s1;
  lane_norm_t s2;
  logic [31:0] s3;

  lane_prod_t s1_next;
  lane_norm_t s2_next;
  logic [31:0] s3_next;
  logic        neg;
  logic [MAG_W-1:0] mag;
  logic [SIG_W-1:0] sig;
  logic [8:0]  esum;
  logic [8:0]  ne;
  logic [PROD_W-1:0] shifted;
  logic [7:0]  subsh;

  always_comb begin
    neg  = nibble < NIB_MID;
    mag  = neg ? (NIB_MID - nibble) : (nibble - NIB_MID);
    sig  = {sdec.hidden, sdec.man, 16'h0};
    s1_next.sign = sdec.sign ^ neg;
    s1_next.bexp = sdec.bexp;
    s1_next.prod = PROD_W'(sig) * PROD_W'(mag);
    s1_next.special     = 1'b0;
    s1_next.special_val = '0;
    if (sdec.is_nan) begin
      s1_next.special     = 1'b1;
      s1_next.special_val = {sdec.sign, 8'hFF, 1'b1, sdec.man[5:0], 16'h0};
    end else if (sdec.is_inf) begin
      s1_next.special     = 1'b1;
      s1_next.special_val = (mag == '0) ? QNAN_CANON : {sdec.sign ^ neg, INF_BITS};
    end else if (mag == '0 || sdec.is_zero) begin
      s1_next.special     = 1'b1;
      s1_next.special_val = {sdec.sign ^ neg, 31'h0};
    end
  end

  always_comb begin
    s2_next.sign        = s1.sign;
    s2_next.prod        = s1.prod;
    s2_next.bexp        = s1.bexp;
    s2_next.special     = s1.special;
    s2_next.special_val = s1.special_val;
    s2_next.msb         = find_msb(s1.prod);
  end

  always_comb begin
    esum  = 9'(s2.bexp) + 9'(s2.msb);
    ne    = esum - 9'd23;
    subsh = s2.bexp - 8'd1;
    shifted = (s2.msb >= MSB_W'(23)) ? (s2.prod >> (s2.msb - MSB_W'(23)))
                                     : (s2.prod << (MSB_W'(23) - s2.msb));
    if (s2.special) begin
      s3_next = s2.special_val;
    end else if (esum <= 9'd23) begin
      s3_next = {s2.sign, 8'h0, 23'(s2.prod << subsh)};
    end else if (ne >= 9'd255) begin
      s3_next = {s2.sign, INF_BITS};
    end else begin
      s3_next = {s2.sign, ne[7:0], shifted[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in) s1 <= s1_next;
    if (adv[0]) s2 <= s2_next;
    if (adv[1]) s3 <= s3_next;
  end

  assign result = s3;

endmodule

@@ sv/q4_nibble_dequantizer_top.sv @@
// ----------------------------------------------------------------------------
// q4_nibble_dequantizer_top: Q4 weight byte to two float32 values
// Scales both nibbles (minus 8) of a byte by a bfloat16 scale, exactly.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------
//  in      | in_valid / in_ready  | in_item  (scale_word, weight_pair)
//  out     | out_valid / out_ready| out_item (low_weight, high_weight)
//
// Each item passes the multiply, leading-one search and normalize/pack registers in turn.
// One transaction per cycle is sustained while out_ready is high; each stage holds when the one
// after it is full and stalled, so bubbles collapse and nothing repeats.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module q4_nibble_dequantizer_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  q4dq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output q4dq_pkg::out_item_t out_item
);
  import q4dq_pkg::*;

  logic [2:0] vld;
  logic [2:0] go;   // stage i loads this cycle
  scale_dec_t sdec;
  logic [31:0] lo_res, hi_res;

  always_comb begin
    go[2] = vld[1] & (~vld[2] | out_ready);
    go[1] = vld[0] & (~vld[1] | go[2]);
    go[0] = in_valid & (~vld[0] | go[1]);
  end

  assign in_ready  = ~vld[0] | go[1];
  assign out_valid = vld[2];

  always_comb begin
    sdec.sign    = in_item.scale_word[15];
    sdec.man     = in_item.scale_word[6:0];
    sdec.is_nan  = (in_item.scale_word[14:7] == 8'hFF) && (sdec.man != '0);
    sdec.is_inf  = (in_item.scale_word[14:7] == 8'hFF) && (sdec.man == '0);
    sdec.is_zero = (in_item.scale_word[14:0] == '0);
    sdec.hidden  = (in_item.scale_word[14:7] != 8'h0);
    sdec.bexp    = sdec.hidden ? in_item.scale_word[14:7] : 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) vld[0] <= 1'b1; else if (go[1]) vld[0] <= 1'b0;
      if (go[1]) vld[1] <= 1'b1; else if (go[2]) vld[1] <= 1'b0;
      if (go[2]) vld[2] <= 1'b1; else if (out_ready) vld[2] <= 1'b0;
    end
  end

  q4dq_lane u_lo (
    .clk    (clk),
    .adv    (go[2:1]),
    .adv_in (go[0]),
    .sdec   (sdec),
    .nibble (in_item.weight_pair[3:0]),
    .result (lo_res)
  );

  q4dq_lane u_hi (
    .clk    (clk),
    .adv    (go[2:1]),
    .adv_in (go[0]),
    .sdec   (sdec),
    .nibble (in_item.weight_pair[7:4]),
    .result (hi_res)
  );

  assign out_item.low_weight  = lo_res;
  assign out_item.high_weight = hi_res;

endmodule

@@ dv/tb_q4_nibble_dequantizer_top.sv @@
// ----------------------------------------------------------------------------
// tb_q4_nibble_dequantizer_top: testbench for the Q4 nibble dequantizer
// Drives weight bytes with bfloat16 scales through a directed table and a
// random stream, predicts both float32 products and checks every transaction.
// ----------------------------------------------------------------------------
module tb_q4_nibble_dequantizer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import q4dq_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [31:0] NO_CHECK = 32'hDEAD_BEEF;

  typedef struct {
    logic [15:0] scale;
    logic [7:0]  pair;
    logic        fixed;
    logic [31:0] low_exp;
    logic [31:0] high_exp;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  out_item_t expected_q[$];
  int        mismatches = 0;
  int        unexpected = 0;
  int        checked = 0;
  int        cycles = 0;
  int        specials = 0;
  bit        stim_done = 1'b0;
  stim_row_t rows[$];

  q4_nibble_dequantizer_top u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One nibble (minus 8) times a bfloat16 scale, exact, float32 bits out.
  function automatic logic [31:0] scaled_nibble(logic [15:0] scale, logic [3:0] nib);
    logic        s_sign, neg, p_sign;
    logic [7:0]  s_exp;
    logic [6:0]  s_man;
    logic [3:0]  mag;
    logic [27:0] prod;
    int          e, msb, ne;
    s_sign = scale[15];
    s_exp  = scale[14:7];
    s_man  = scale[6:0];
    neg    = nib < NIB_MID;
    mag    = neg ? NIB_MID - nib : nib - NIB_MID;
    p_sign = s_sign ^ neg;
    if (s_exp == 8'hFF) begin
      if (s_man != 0) return {scale, 16'h0} | 32'h0040_0000;
      if (mag == 0) return QNAN_CANON;
      return {p_sign, INF_BITS};
    end
    if (mag == 0 || (s_exp == 0 && s_man == 0)) return {p_sign, 31'h0};
    if (s_exp == 0) begin
      prod = 28'({s_man, 16'h0}) * mag;
      e = 1;
    end else begin
      prod = 28'({1'b1, s_man, 16'h0}) * mag;
      e = s_exp;
    end
    msb = 0;
    for (int i = 0; i < 28; i++) if (prod[i]) msb = i;
    if (e + msb <= 23) return {p_sign, 8'h0, 23'(prod << (e - 1))};
    ne = e + msb - 23;
    if (ne >= 255) return {p_sign, INF_BITS};
    if (msb >= 23) prod = prod >> (msb - 23);
    else prod = prod << (23 - msb);
    return {p_sign, 8'(ne), prod[22:0]};
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  function automatic logic [15:0] rand_scale();
    logic [15:0] s;
    s = 16'($urandom);
    case ($urandom_range(0, 9))
      0: s[14:7] = 8'h00;
      1: s[14:7] = 8'hFF;
      2: s[14:7] = 8'hFC + 8'($urandom_range(0, 2));
      3: s[14:7] = 8'($urandom_range(1, 3));
      default: ;
    endcase
    return s;
  endfunction

  task automatic send(logic [15:0] scale, logic [7:0] pair, logic fixed,
                      logic [31:0] lo, logic [31:0] hi);
    out_item_t exp_item;
    // Typed-in rows are checked against their own values.
    if (fixed) begin
      exp_item.low_weight  = lo;
      exp_item.high_weight = hi;
    end else begin
      exp_item.low_weight  = scaled_nibble(scale, pair[3:0]);
      exp_item.high_weight = scaled_nibble(scale, pair[7:4]);
    end
    if (scale[14:7] == 8'hFF || scale[14:7] == 8'h00) specials++;
    in_item  <= '{scale_word: scale, weight_pair: pair};
    in_valid <= 1'b1;
    expected_q.push_back(exp_item);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    // Directed rows: extremes, signed zeros, subnormals, infinities, NaNs.
    rows.push_back('{16'h3F80, 8'h08, 1, 32'h0000_0000, 32'hC100_0000});
    rows.push_back('{16'h3F80, 8'hF0, 1, 32'hC100_0000, 32'h40E0_0000});
    rows.push_back('{16'hBF80, 8'h88, 1, 32'h8000_0000, 32'h8000_0000});
    rows.push_back('{16'h0000, 8'h07, 1, 32'h8000_0000, 32'h8000_0000});
    rows.push_back('{16'h8000, 8'h9F, 1, 32'h8000_0000, 32'h8000_0000});
    rows.push_back('{16'h7F80, 8'h8F, 1, 32'h7F80_0000, 32'h7FC0_0000});
    rows.push_back('{16'hFF80, 8'h08, 1, 32'h7FC0_0000, 32'h7F80_0000});
    rows.push_back('{16'hFF80, 8'h0F, 1, 32'hFF80_0000, 32'h7F80_0000});
    rows.push_back('{16'h7FC1, 8'h3C, 1, 32'h7FC1_0000, 32'h7FC1_0000});
    rows.push_back('{16'hFF81, 8'h00, 1, 32'hFFC1_0000, 32'hFFC1_0000});
    rows.push_back('{16'h7F7F, 8'h00, 1, 32'hFF80_0000, 32'hFF80_0000});
    rows.push_back('{16'h7F7F, 8'hF9, 0, 0, 0});
    rows.push_back('{16'h0001, 8'h0F, 0, 0, 0});
    rows.push_back('{16'h807F, 8'hF0, 0, 0, 0});
    rows.push_back('{16'h007F, 8'h7A, 0, 0, 0});
    rows.push_back('{16'h0080, 8'h00, 0, 0, 0});
    rows.push_back('{16'h3FFF, 8'hE1, 0, 0, 0});
    rows.push_back('{16'hC2AA, 8'h5B, 0, 0, 0});
    rows.push_back('{16'h7E00, 8'h0F, 0, 0, 0});
    rows.push_back('{16'h0040, 8'h2D, 0, 0, 0});
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send(rows[i].scale, rows[i].pair, rows[i].fixed, rows[i].low_exp, rows[i].high_exp);
      idle_gap($urandom_range(0, 1));
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Hold off until the pipeline has drained once mid-run.
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      send(rand_scale(), 8'($urandom), 1'b0, NO_CHECK, NO_CHECK);
      if (n % 200 < 120) idle_gap(gap_len());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, with bursts of constant ready.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ((cycles / 500) % 3 != 0 && $urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    out_item_t exp_item;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("tb: unexpected transaction %h", out_item);
      end else begin
        exp_item = expected_q.pop_front();
        checked++;
        if (out_item.low_weight !== exp_item.low_weight ||
            out_item.high_weight !== exp_item.high_weight) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("tb: mismatch low exp %h got %h, high exp %h got %h",
                     exp_item.low_weight, out_item.low_weight,
                     exp_item.high_weight, out_item.high_weight);
        end
      end
    end
  end

  initial begin
    wait (stim_done && expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: checked %0d transactions, %0d with zero, subnormal or special scales",
             checked, specials);
    $display("tb: including a full drain mid-run and random stalls on both sides");
    if (mismatches == 0 && unexpected == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("tb: timeout");
    $display("tb: failure");
    $finish;
  end
endmodule
